// ===== rtl/core/pmc_pkg.sv =====
// shared types, constants and codes of the position motor controller
package pmc_pkg;

  localparam int unsigned COUNTS_PER_REV = 4840;
  localparam int unsigned CPR_W          = $clog2(COUNTS_PER_REV);
  localparam int unsigned FULL_TURN      = 46080;
  localparam int unsigned HALF_TURN      = 23040;
  localparam int unsigned BOOST_END      = 1536;

  localparam logic [2:0] CFG_KP           = 3'd0;
  localparam logic [2:0] CFG_KI_TS        = 3'd1;
  localparam logic [2:0] CFG_KD_RATE      = 3'd2;
  localparam logic [2:0] CFG_INTEG_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_DEADZONE     = 3'd4;
  localparam logic [2:0] CFG_PWM_MAX      = 3'd5;
  localparam logic [2:0] CFG_PWM_MIN      = 3'd6;
  localparam logic [2:0] CFG_STATIC_BOOST = 3'd7;

  typedef struct packed {
    logic               action;
    logic signed [31:0] encoder_count;
    logic        [15:0] target_angle;
  } pmc_in_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       direction;
    logic       in_deadzone;
  } pmc_out_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } pmc_op_t;

  typedef struct packed {
    pmc_op_t     op;
    logic [63:0] a;
    logic [31:0] b;
    logic [6:0]  len;
  } pmc_unit_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_ANG,
    S_VEL,
    S_VELF,
    S_INTEG,
    S_PROP,
    S_DERIV,
    S_BOOST,
    S_RAW,
    S_DUTY,
    S_OUT
  } pmc_state_t;

endpackage

// ===== rtl/core/pmc_serial_unit.sv =====
// bit-serial shift-add multiplier and restoring divider, one bit per cycle
module pmc_serial_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  pmc_pkg::pmc_unit_req_t req,
  output logic                   done,
  output logic [63:0]            q,
  output logic [31:0]            r
);
  import pmc_pkg::*;

  logic        busy;
  logic [6:0]  cnt;
  pmc_op_t     op;
  logic [63:0] x;
  logic [31:0] y;
  logic [63:0] acc;
  logic [32:0] rem;
  logic [32:0] shifted;
  logic [33:0] diff;

  assign shifted = {rem[31:0], x[63]};
  assign diff    = {1'b0, shifted} - {2'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= req.len;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op  <= req.op;
      x   <= req.a;
      y   <= req.b;
      acc <= '0;
      rem <= '0;
    end else if (busy) begin
      x <= x << 1;
      unique case (op)
        OP_MUL: begin
          if (y[0]) acc <= acc + x;
          y <= y >> 1;
        end
        OP_DIV: begin
          acc <= {acc[62:0], ~diff[33]};
          rem <= diff[33] ? shifted : diff[32:0];
        end
      endcase
    end
  end

  assign q = acc;
  assign r = rem[31:0];

endmodule

// ===== rtl/core/pid_position_motor_control.sv =====
// top level: position PI-D controller sequencer around a shared serial unit
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_data   (pmc_in_t)
// out     | output    | out_valid/out_stall| out_data  (pmc_out_t)
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// the serial unit runs one bit per cycle through modulo, angle, velocity, three
// gain products and the boost ramp divide; a tick skips it at full boost and
// in the deadzone skips from velocity filter to output; a clear stays in idle.
// rst is synchronous; state, config and filter registers reset, operands do not.
// out_valid holds under out_stall; the next request is taken while a result waits.
module pid_position_motor_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pmc_pkg::pmc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pmc_pkg::pmc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  import pmc_pkg::*;

  logic [23:0] kp, ki_ts, kd_rate;
  logic [7:0]  integ_limit, pwm_max, pwm_min, static_boost;
  logic [10:0] deadzone;

  logic [31:0]        prev_count;
  logic signed [31:0] integ;
  logic signed [31:0] vel_f;
  logic [23:0]        duty_f;
  logic               last_dir;

  pmc_state_t state, state_next;
  logic               launched;
  logic               unit_start, unit_done;
  pmc_unit_req_t      req;
  logic [63:0]        uq;
  logic [31:0]        ur;

  logic signed [31:0] enc;
  logic [15:0]        tgt;
  logic [CPR_W-1:0]   m;
  logic signed [15:0] err;
  logic [14:0]        ae;
  logic signed [31:0] w;
  logic signed [57:0] u;
  logic [30:0]        boost;
  logic [7:0]         raw8;
  pmc_out_t           res;

  logic in_accept, can_load, in_dz, full_boost;
  logic [31:0] emag, d, dmag, vmag, ang_prod;
  logic [47:0] vprod;
  logic [18:0] bdiv;
  logic [10:0] bden;

  assign in_accept  = in_valid && !in_stall;
  assign can_load   = !out_valid || !out_stall;
  assign in_dz      = ae < {4'b0, deadzone};
  assign full_boost = ae >= 15'(BOOST_END);
  assign emag       = enc[31] ? 32'(-enc) : 32'(enc);
  assign d          = enc - prev_count;
  assign dmag       = d[31] ? -d : d;
  assign vmag       = vel_f[31] ? 32'(-vel_f) : 32'(vel_f);
  assign ang_prod   = 32'(m) * 32'(FULL_TURN);
  assign vprod      = 48'(dmag) * 48'(FULL_TURN);
  assign bdiv       = 19'(static_boost) * 19'(ae[10:0] - deadzone);
  assign bden       = 11'(BOOST_END) - deadzone;

  pmc_serial_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .req   (req),
    .done  (unit_done),
    .q     (uq),
    .r     (ur)
  );

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp           <= 24'd5767;
      ki_ts        <= 24'd102;
      kd_rate      <= 24'd0;
      integ_limit  <= 8'd150;
      deadzone     <= 11'd102;
      pwm_max      <= 8'd140;
      pwm_min      <= 8'd45;
      static_boost <= 8'd18;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KP:           kp           <= cfg_data;
        CFG_KI_TS:        ki_ts        <= cfg_data;
        CFG_KD_RATE:      kd_rate      <= cfg_data;
        CFG_INTEG_LIMIT:  integ_limit  <= cfg_data[7:0];
        CFG_DEADZONE:     deadzone     <= cfg_data[10:0];
        CFG_PWM_MAX:      pwm_max      <= cfg_data[7:0];
        CFG_PWM_MIN:      pwm_min      <= cfg_data[7:0];
        CFG_STATIC_BOOST: static_boost <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_accept && !in_data.action) state_next = S_MOD;
      S_MOD:   if (unit_done) state_next = S_ANG;
      S_ANG:   if (unit_done) state_next = S_VEL;
      S_VEL:   if (unit_done) state_next = S_VELF;
      S_VELF:  state_next = in_dz ? S_OUT : S_INTEG;
      S_INTEG: if (unit_done) state_next = S_PROP;
      S_PROP:  if (unit_done) state_next = S_DERIV;
      S_DERIV: if (unit_done) state_next = S_BOOST;
      S_BOOST: if (full_boost || unit_done) state_next = S_RAW;
      S_RAW:   state_next = S_DUTY;
      S_DUTY:  state_next = S_OUT;
      S_OUT:   if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req        = '{op: OP_MUL, a: '0, b: '0, len: 7'd1};
    unit_start = 1'b0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_MOD: begin
        req        = '{op: OP_DIV, a: {emag, 32'b0}, b: 32'(COUNTS_PER_REV), len: 7'd32};
        unit_start = !launched;
      end
      S_ANG: begin
        req        = '{op: OP_DIV, a: {ang_prod, 32'b0}, b: 32'(COUNTS_PER_REV),
                       len: 7'd32};
        unit_start = !launched;
      end
      S_VEL: begin
        req        = '{op: OP_DIV, a: {vprod, 16'b0}, b: 32'(COUNTS_PER_REV), len: 7'd48};
        unit_start = !launched;
      end
      S_INTEG: begin
        req        = '{op: OP_MUL, a: 64'(ki_ts), b: 32'(ae), len: 7'd15};
        unit_start = !launched;
      end
      S_PROP: begin
        req        = '{op: OP_MUL, a: 64'(kp), b: 32'(ae), len: 7'd15};
        unit_start = !launched;
      end
      S_DERIV: begin
        req        = '{op: OP_MUL, a: 64'(kd_rate), b: vmag, len: 7'd32};
        unit_start = !launched;
      end
      S_BOOST: begin
        req        = '{op: OP_DIV, a: {bdiv, 45'b0}, b: 32'(bden), len: 7'd42};
        unit_start = !launched && !full_boost;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (unit_start) launched <= 1'b1;
      else if (unit_done) launched <= 1'b0;
      if (state == S_OUT && can_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  logic signed [17:0] e0;
  logic [15:0]        ang;
  logic signed [40:0] pi_term;
  logic signed [41:0] isum, lim;
  logic signed [57:0] pk_term, kd_term;
  logic [57:0]        au, usum;
  logic [34:0]        rawv;
  logic [7:0]         c1;
  logic signed [34:0] vsum;
  logic [25:0]        dsum;

  assign ang     = uq[15:0];
  assign e0      = $signed({2'b0, tgt}) - $signed({2'b0, ang});
  assign pi_term = err[15] ? -$signed({2'b0, uq[38:0]}) : $signed({2'b0, uq[38:0]});
  assign isum    = 42'(integ) + 42'(pi_term);
  assign lim     = $signed({11'b0, integ_limit, 23'b0});
  assign pk_term = err[15] ? -$signed({19'b0, uq[38:0]}) : $signed({19'b0, uq[38:0]});
  assign kd_term = vel_f[31] ? -$signed({2'b0, uq[55:0]}) : $signed({2'b0, uq[55:0]});
  assign au      = u[57] ? 58'(-u) : 58'(u);
  assign usum    = au + {27'b0, boost};
  assign rawv    = usum[57:23];
  assign c1      = (rawv > 35'(pwm_max)) ? pwm_max : rawv[7:0];
  assign vsum    = 35'(w) + 35'(vel_f) + (35'(vel_f) <<< 1);
  assign dsum    = {2'b0, raw8, 16'b0} + 26'(duty_f) + (26'(duty_f) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
      integ      <= '0;
      vel_f      <= '0;
      duty_f     <= '0;
      last_dir   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_accept && in_data.action) begin
          integ  <= '0;
          duty_f <= '0;
        end
        S_VELF: begin
          vel_f      <= vsum[33:2];
          prev_count <= enc;
          if (in_dz) begin
            integ  <= '0;
            duty_f <= '0;
          end
        end
        S_INTEG: if (unit_done) begin
          if (isum > lim) integ <= lim[31:0];
          else if (isum < -lim) integ <= 32'(-lim);
          else integ <= isum[31:0];
        end
        S_DUTY: begin
          duty_f   <= dsum[25:2];
          last_dir <= !u[57];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_accept) begin
        enc <= in_data.encoder_count;
        tgt <= in_data.target_angle;
      end
      S_MOD: if (unit_done) begin
        if (enc[31] && ur != '0) m <= CPR_W'(32'(COUNTS_PER_REV) - ur);
        else m <= ur[CPR_W-1:0];
      end
      S_ANG: if (unit_done) begin
        if (e0 > 18'sd23040) begin
          err <= 16'(e0 - 18'sd46080);
          ae  <= 15'(18'sd46080 - e0);
        end else if (e0 < -18'sd23040) begin
          err <= 16'(e0 + 18'sd46080);
          ae  <= 15'(e0 + 18'sd46080);
        end else begin
          err <= e0[15:0];
          ae  <= e0[17] ? 15'(-e0) : e0[14:0];
        end
      end
      S_VEL: if (unit_done) begin
        if (!d[31]) w <= (uq[47:0] > 48'h7fff_ffff) ? 32'sh7fff_ffff : $signed(uq[31:0]);
        else w <= (uq[47:0] > 48'h8000_0000) ? 32'sh8000_0000 : -$signed(uq[31:0]);
      end
      S_VELF: if (in_dz) res <= '{pwm_duty: 8'd0, direction: last_dir, in_deadzone: 1'b1};
      S_PROP: if (unit_done) u <= pk_term + 58'(integ);
      S_DERIV: if (unit_done) u <= u - kd_term;
      S_BOOST: begin
        if (full_boost) boost <= {static_boost, 23'b0};
        else if (unit_done) boost <= uq[30:0];
      end
      S_RAW: raw8 <= (c1 < pwm_min) ? pwm_min : c1;
      S_DUTY: res <= '{pwm_duty: dsum[25:18], direction: !u[57], in_deadzone: 1'b0};
      S_OUT: if (can_load) out_data <= res;
      default: ;
    endcase
  end

endmodule
